### hdl/ovn_pkg.sv
`timescale 1ns / 1ps

package ovn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int MAX_DIM     = 4096;

    localparam int PIX_W   = 12;
    localparam int FREQ_W  = 16;
    localparam int PERS_W  = 16;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 4;
    localparam int SEED_W  = 64;
    localparam int IDX_W   = 3;
    localparam int OUT_W   = 8;
    localparam int FRAC_W  = 16;

    // pixel * frequency, then Q8 lattice scale and the top octave shift
    localparam int PROD_W  = PIX_W + FREQ_W;
    localparam int Q_W     = PROD_W + 8 + MAX_OCTAVES - 1;

    // only the low 31 bits of the hash survive the final mask
    localparam int HASH_W  = 31;
    localparam int AMP_W   = 17;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 33;
    localparam int MUL_W   = 50;
    localparam int OCT_LAT = 11;

    localparam logic [HASH_W-1:0] HASH_ROW   = 31'd257;
    localparam int                HASH_SHIFT = 13;
    localparam logic [HASH_W-1:0] HASH_MUL_A = 31'd15731;
    localparam logic [HASH_W-1:0] HASH_ADD_A = 31'd789221;
    localparam logic [HASH_W-1:0] HASH_ADD_B = 31'd1376312589;

    localparam logic signed [VAL_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [AMP_W-1:0]        AMP_ONE = 17'h1_0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_OCTAVE_COUNT   = 3'd0,
        CFG_PERSISTENCE    = 3'd1,
        CFG_BASE_FREQUENCY = 3'd2,
        CFG_HASH_SEED      = 3'd3,
        CFG_IMAGE_WIDTH    = 3'd4,
        CFG_IMAGE_HEIGHT   = 3'd5
    } cfg_reg_t;

endpackage

### hdl/ovn_octave.sv
`timescale 1ns / 1ps

module ovn_octave (
    input  logic                              clk,
    input  logic [ovn_pkg::Q_W-1:0]           qx,
    input  logic [ovn_pkg::Q_W-1:0]           qy,
    input  logic [ovn_pkg::HASH_W-1:0]        seed,
    input  logic [ovn_pkg::AMP_W-1:0]         amp,
    output logic signed [ovn_pkg::VAL_W-1:0]  term
);
    import ovn_pkg::*;

    // divide by 2^16, rounding toward zero
    function automatic logic signed [MUL_W-FRAC_W-1:0] trunc16(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0] adj;
        adj = p + ((p < 0) ? 50'sd65535 : 50'sd0);
        return adj[MUL_W-1:FRAC_W];
    endfunction

    logic [HASH_W-1:0] xc [2];
    logic [HASH_W-1:0] yc [2];
    logic [FRAC_W-1:0] t_w [2];

    logic [HASH_W-1:0] mix_next [4];
    logic [HASH_W-1:0] mix_reg  [4];
    logic [HASH_W-1:0] sq_reg   [4];
    logic [HASH_W-1:0] m2_reg   [4];
    logic [HASH_W-1:0] ha_reg   [4];
    logic [HASH_W-1:0] m3_reg   [4];
    logic [HASH_W-1:0] hb_reg   [4];
    logic signed [VAL_W-1:0] v_reg [4];

    logic [FRAC_W-1:0] t_reg   [2];
    logic [FRAC_W-1:0] t2_reg  [2];
    logic [FRAC_W-1:0] t3_reg  [2];
    logic [19:0]       pp_reg  [2];
    logic [FRAC_W-1:0] s_next  [2];
    logic [FRAC_W-1:0] s3_reg  [2];
    logic [FRAC_W-1:0] s4_reg  [2];
    logic [FRAC_W-1:0] s5_reg  [2];
    logic [FRAC_W-1:0] sy6_reg;
    logic [FRAC_W-1:0] sy7_reg;

    logic signed [MUL_W-1:0] p0_next;
    logic signed [MUL_W-1:0] p1_next;
    logic signed [MUL_W-1:0] p0_reg;
    logic signed [MUL_W-1:0] p1_reg;
    logic signed [VAL_W-1:0] v0_reg;
    logic signed [VAL_W-1:0] v2_reg;
    logic signed [VAL_W-1:0] l0_reg;
    logic signed [VAL_W-1:0] l1_reg;
    logic signed [VAL_W-1:0] l0d_reg;
    logic signed [MUL_W-1:0] py_next;
    logic signed [MUL_W-1:0] py_reg;
    logic signed [VAL_W-1:0] e_reg;
    logic signed [MUL_W-1:0] pa_next;
    logic signed [MUL_W-1:0] pa_reg;
    logic signed [VAL_W-1:0] term_reg;

    always_comb
    begin
        logic [HASH_W-1:0] n;
        xc[0]  = HASH_W'(qx >> FRAC_W);
        xc[1]  = xc[0] + 31'd1;
        yc[0]  = HASH_W'(qy >> FRAC_W);
        yc[1]  = yc[0] + 31'd1;
        t_w[0] = qx[FRAC_W-1:0];
        t_w[1] = qy[FRAC_W-1:0];
        for (int c = 0; c < 4; c++)
        begin
            // corner order: bit 0 picks x+1, bit 1 picks y+1
            n = HASH_W'(xc[c[0]] + yc[c[1]] * HASH_ROW);
            mix_next[c] = HASH_W'(n << HASH_SHIFT) ^ n ^ seed;
        end
    end

    always_comb
    begin
        logic [35:0] sp;
        for (int a = 0; a < 2; a++)
        begin
            sp = (36'(t3_reg[a]) * 36'(pp_reg[a])) >> FRAC_W;
            s_next[a] = (sp > 36'd65535) ? 16'hFFFF : FRAC_W'(sp);
        end
    end

    always_comb
    begin
        logic signed [VAL_W:0] d0;
        logic signed [VAL_W:0] d1;
        logic signed [VAL_W:0] dy;
        d0      = SUM_W'(v_reg[1]) - SUM_W'(v_reg[0]);
        d1      = SUM_W'(v_reg[3]) - SUM_W'(v_reg[2]);
        p0_next = d0 * $signed({1'b0, s5_reg[0]});
        p1_next = d1 * $signed({1'b0, s5_reg[0]});
        dy      = SUM_W'(l1_reg) - SUM_W'(l0_reg);
        py_next = dy * $signed({1'b0, sy7_reg});
        pa_next = e_reg * $signed({1'b0, amp});
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            mix_reg[c] <= mix_next[c];
            sq_reg[c]  <= HASH_W'(mix_reg[c] * mix_reg[c]);
            m2_reg[c]  <= mix_reg[c];
            ha_reg[c]  <= HASH_W'(sq_reg[c] * HASH_MUL_A + HASH_ADD_A);
            m3_reg[c]  <= m2_reg[c];
            hb_reg[c]  <= HASH_W'(m3_reg[c] * ha_reg[c] + HASH_ADD_B);
            v_reg[c]   <= ONE_Q30 - $signed({1'b0, hb_reg[c]});
        end
        for (int a = 0; a < 2; a++)
        begin
            t_reg[a]  <= t_w[a];
            t2_reg[a] <= FRAC_W'((32'(t_w[a]) * 32'(t_w[a])) >> FRAC_W);
            t3_reg[a] <= FRAC_W'((32'(t2_reg[a]) * 32'(t_reg[a])) >> FRAC_W);
            pp_reg[a] <= 20'(24'(t2_reg[a]) * 24'd6 + 24'd655360 - 24'(t_reg[a]) * 24'd15);
            s3_reg[a] <= s_next[a];
            s4_reg[a] <= s3_reg[a];
            s5_reg[a] <= s4_reg[a];
        end
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        v0_reg   <= v_reg[0];
        v2_reg   <= v_reg[2];
        sy6_reg  <= s5_reg[1];
        l0_reg   <= VAL_W'(34'(v0_reg) + trunc16(p0_reg));
        l1_reg   <= VAL_W'(34'(v2_reg) + trunc16(p1_reg));
        sy7_reg  <= sy6_reg;
        py_reg   <= py_next;
        l0d_reg  <= l0_reg;
        e_reg    <= VAL_W'(34'(l0d_reg) + trunc16(py_reg));
        pa_reg   <= pa_next;
        term_reg <= VAL_W'(trunc16(pa_reg));
    end

    assign term = term_reg;

endmodule

### hdl/octave_value_noise_pixel.sv
`timescale 1ns / 1ps

// done and intensity are registered and come up together for each accepted pixel
// throughput: one pixel per cycle; busy stays low, the pipeline never stalls
// the pipeline runs through the 43-step restoring coordinate divider, the 11-stage
// octave units, one clamp-and-add stage per octave and the output register
// reset: asynchronous active low, clears the valid chain and loads register defaults
module octave_value_noise_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ovn_pkg::PIX_W-1:0]     pixel_x,
    input  logic [ovn_pkg::PIX_W-1:0]     pixel_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ovn_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ovn_pkg::SEED_W-1:0]    cfg_data,
    output logic                          done,
    output logic [ovn_pkg::OUT_W-1:0]     intensity
);
    import ovn_pkg::*;

    localparam int VLD_N = 1 + Q_W + OCT_LAT + MAX_OCTAVES;

    logic [CNT_W-1:0]  octave_count_reg;
    logic [PERS_W-1:0] persistence_reg;
    logic [FREQ_W-1:0] base_frequency_reg;
    logic [SEED_W-1:0] hash_seed_reg;
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;

    logic [DIM_W-1:0]  dim [2];
    logic [PIX_W-1:0]  pix [2];
    logic [CNT_W-1:0]  cnt;

    logic [Q_W-1:0]    dw_reg   [2][Q_W+1];
    logic [DIM_W-1:0]  rem_reg  [2][Q_W+1];
    logic [Q_W-1:0]    dw_next  [2][Q_W];
    logic [DIM_W-1:0]  rem_next [2][Q_W];

    logic [AMP_W-1:0]        amp_reg [MAX_OCTAVES];
    logic signed [VAL_W-1:0] term_w  [MAX_OCTAVES];
    logic signed [VAL_W-1:0] tpipe_reg [MAX_OCTAVES][MAX_OCTAVES];
    logic signed [VAL_W-1:0] total_reg  [MAX_OCTAVES];
    logic signed [VAL_W-1:0] total_next [MAX_OCTAVES];

    logic [VLD_N-1:0]  vld_reg;
    logic              done_reg;
    logic [OUT_W-1:0]  intensity_reg;
    logic [OUT_W-1:0]  intensity_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg   <= 4'd3;
            persistence_reg    <= 16'd32768;
            base_frequency_reg <= 16'd6400;
            hash_seed_reg      <= '0;
            image_width_reg    <= 13'd256;
            image_height_reg   <= 13'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_PERSISTENCE:    persistence_reg    <= cfg_data[PERS_W-1:0];
                CFG_BASE_FREQUENCY: base_frequency_reg <= cfg_data[FREQ_W-1:0];
                CFG_HASH_SEED:      hash_seed_reg      <= cfg_data;
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        dim[0] = (image_width_reg == '0) ? 13'd1 :
                 (image_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width_reg;
        dim[1] = (image_height_reg == '0) ? 13'd1 :
                 (image_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height_reg;
        cnt    = (octave_count_reg > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                          : octave_count_reg;
        pix[0] = pixel_x;
        pix[1] = pixel_y;
    end

    // restoring divider, one quotient bit per stage; the dividend shifts out
    // of the top while quotient bits shift in at the bottom
    always_comb
    begin
        logic [DIM_W:0] trial;
        logic           ge;
        for (int a = 0; a < 2; a++)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                trial = {rem_reg[a][k], dw_reg[a][k][Q_W-1]};
                ge    = (trial >= {1'b0, dim[a]});
                rem_next[a][k] = ge ? DIM_W'(trial - {1'b0, dim[a]}) : DIM_W'(trial);
                dw_next[a][k]  = {dw_reg[a][k][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            dw_reg[a][0]  <= Q_W'(PROD_W'(pix[a]) * PROD_W'(base_frequency_reg)) << (Q_W - PROD_W);
            rem_reg[a][0] <= '0;
            for (int k = 0; k < Q_W; k++)
            begin
                dw_reg[a][k+1]  <= dw_next[a][k];
                rem_reg[a][k+1] <= rem_next[a][k];
            end
        end
    end

    // amplitude ladder, settles rung by rung after persistence changes
    always_ff @(posedge clk)
    begin
        amp_reg[0] <= AMP_ONE;
        for (int k = 1; k < MAX_OCTAVES; k++)
        begin
            amp_reg[k] <= AMP_W'((33'(amp_reg[k-1]) * 33'(persistence_reg)) >> FRAC_W);
        end
    end

    // octave k takes the top quotient scaled down to its own frequency
    for (genvar g = 0; g < MAX_OCTAVES; g++)
    begin : g_oct
        ovn_octave u_octave (
            .clk  (clk),
            .qx   (dw_reg[0][Q_W] >> (MAX_OCTAVES - 1 - g)),
            .qy   (dw_reg[1][Q_W] >> (MAX_OCTAVES - 1 - g)),
            .seed (hash_seed_reg[HASH_W-1:0]),
            .amp  (amp_reg[g]),
            .term (term_w[g])
        );
    end

    // running total, clamped after every octave in order
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [VAL_W-1:0] prev;
        logic signed [VAL_W-1:0] add;
        logic [VAL_W-1:0]        biased;
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            prev = (k == 0) ? '0 : total_reg[(k == 0) ? 0 : k - 1];
            if (k == 0)
                add = term_w[0];
            else
                add = tpipe_reg[(k == 0) ? 0 : k - 1][k];
            if (CNT_W'(k) >= cnt)
                add = '0;
            sum = SUM_W'(prev) + SUM_W'(add);
            if (sum > SUM_W'(ONE_Q30))
                total_next[k] = ONE_Q30;
            else if (sum < -SUM_W'(ONE_Q30))
                total_next[k] = -ONE_Q30;
            else
                total_next[k] = VAL_W'(sum);
        end
        biased         = VAL_W'(total_reg[MAX_OCTAVES-1] + ONE_Q30);
        intensity_next = OUT_W'((40'(biased) * 40'd255) >> 31);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_OCTAVES; k++)
        begin
            total_reg[k] <= total_next[k];
            for (int j = 0; j < MAX_OCTAVES; j++)
            begin
                tpipe_reg[k][j] <= (k == 0) ? term_w[j] : tpipe_reg[(k == 0) ? 0 : k - 1][j];
            end
        end
        intensity_reg <= intensity_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VLD_N-2:0], start && !busy};
            done_reg <= vld_reg[VLD_N-1];
        end
    end

    assign done      = done_reg;
    assign intensity = intensity_reg;

endmodule
